### design/lbi_pkg.sv
`default_nettype none

package lbi_pkg;

   localparam int unsigned POSITION_BITS = 20;
   localparam int unsigned UNIT_BITS = 16;
   localparam int unsigned LINE_BITS = 11;
   localparam int unsigned DIGIT_BITS = 3;
   localparam int unsigned QUEUE_DEPTH = 2;

   localparam logic [UNIT_BITS-1:0] CARRIAGE_RETURN = 16'h000D;
   localparam logic [POSITION_BITS-1:0] POSITION_MAX = '1;

   typedef enum logic [1:0] {
      CMD_APPEND = 2'd0,
      CMD_LOCATE = 2'd1,
      CMD_START  = 2'd2,
      CMD_CLEAR  = 2'd3
   } lbi_cmd_type;

   typedef enum logic [1:0] {
      ST_READY  = 2'd0,
      ST_RANGE  = 2'd1,
      ST_MEMORY = 2'd2
   } lbi_status_type;

   typedef enum logic [2:0] {
      OP_APPEND_TEXT  = 3'd0,
      OP_APPEND_BREAK = 3'd1,
      OP_LOCATE       = 3'd2,
      OP_START_FIRST  = 3'd3,
      OP_START_TABLE  = 3'd4,
      OP_START_BAD    = 3'd5,
      OP_CLEAR        = 3'd6
   } lbi_op_type;

   typedef struct packed {
      logic [1:0]               cmd;
      logic [UNIT_BITS-1:0]     unit;
      logic [POSITION_BITS-1:0] position;
      logic [LINE_BITS-1:0]     line_number;
   } lbi_req_type;

   typedef struct packed {
      lbi_status_type           status;
      logic [LINE_BITS-1:0]     found_line;
      logic                     line_first;
      logic [POSITION_BITS-1:0] start_position;
      logic [LINE_BITS-1:0]     line_count;
      logic [DIGIT_BITS-1:0]    digit_count;
   } lbi_rsp_type;

   typedef struct packed {
      lbi_op_type               op;
      logic [POSITION_BITS-1:0] position;
      logic [LINE_BITS-1:0]     line_number;
   } lbi_job_type;

   // Decimal digits of a line count, never fewer than three.
   function automatic logic [DIGIT_BITS-1:0] lbi_digits(input logic [31:0] count);
      logic [DIGIT_BITS-1:0] digits;
      if (count >= 32'd100000) begin
         digits = 3'd6;
      end else if (count >= 32'd10000) begin
         digits = 3'd5;
      end else if (count >= 32'd1000) begin
         digits = 3'd4;
      end else begin
         digits = 3'd3;
      end
      return digits;
   endfunction

endpackage

`default_nettype wire

### design/lbi_front.sv
`default_nettype none

module lbi_front (
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire lbi_pkg::lbi_req_type req_data,
   input  wire logic                queue_full,
   output logic                     push,
   output lbi_pkg::lbi_job_type     job
);
   import lbi_pkg::*;

   assign req_stall = queue_full;
   assign push = req_valid && !queue_full;

   always_comb begin
      job.position = req_data.position;
      job.line_number = req_data.line_number;
      unique case (req_data.cmd)
         CMD_APPEND: begin
            job.op = (req_data.unit == CARRIAGE_RETURN) ? OP_APPEND_BREAK : OP_APPEND_TEXT;
         end
         CMD_LOCATE: begin
            job.op = OP_LOCATE;
         end
         CMD_START: begin
            if (req_data.line_number == '0) begin
               job.op = OP_START_BAD;
            end else if (req_data.line_number == LINE_BITS'(1)) begin
               job.op = OP_START_FIRST;
            end else begin
               job.op = OP_START_TABLE;
            end
         end
         CMD_CLEAR: begin
            job.op = OP_CLEAR;
         end
         default: begin
            job.op = OP_CLEAR;
         end
      endcase
   end

endmodule

`default_nettype wire

### design/lbi_queue.sv
`default_nettype none

module lbi_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire lbi_pkg::lbi_job_type push_job,
   input  wire logic                 pop,
   output logic                      full,
   output logic                      not_empty,
   output lbi_pkg::lbi_job_type      head_job
);
   import lbi_pkg::*;

   localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned NW = $clog2(QUEUE_DEPTH + 1);

   lbi_job_type slot_ff [QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0] fill_ff, fill_in;
   logic do_push, do_pop;

   assign full = (fill_ff == NW'(QUEUE_DEPTH));
   assign not_empty = (fill_ff != '0);
   assign head_job = slot_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + NW'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

### design/lbi_back.sv
`default_nettype none

module lbi_back #(
   parameter int unsigned MAX_BREAKS = 1024
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 job_valid,
   input  wire lbi_pkg::lbi_job_type job,
   output logic                      pop,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output lbi_pkg::lbi_rsp_type      rsp_data
);
   import lbi_pkg::*;

   localparam int unsigned AW = $clog2(MAX_BREAKS);
   localparam int unsigned TW = $clog2(MAX_BREAKS + 1);
   localparam int unsigned CW = $clog2(MAX_BREAKS + 2);
   localparam int unsigned PB = POSITION_BITS;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SEARCH,
      S_READ,
      S_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic [TW-1:0] total_ff, total_in;
   logic [PB-1:0] length_ff, length_in;
   logic overflow_ff, overflow_in;
   logic [TW-1:0] lo_ff, lo_in;
   logic [TW-1:0] hi_ff, hi_in;
   logic [TW-1:0] mid_ff, mid_in;
   logic [PB-1:0] below_ff, below_in;
   logic [PB-1:0] pos_ff, pos_in;
   lbi_status_type status_ff, status_in;
   logic [LINE_BITS-1:0] found_ff, found_in;
   logic first_ff, first_in;
   logic [PB-1:0] start_ff, start_in;
   logic rsp_valid_ff, rsp_valid_in;
   lbi_rsp_type rsp_data_ff, rsp_data_in;

   logic [PB-1:0] break_table_ff [MAX_BREAKS];
   logic [PB-1:0] rdata_ff;
   logic mem_we;
   logic [AW-1:0] mem_waddr;
   logic [AW-1:0] mem_raddr;

   logic less;
   logic [TW-1:0] next_lo, next_hi;
   logic [TW:0] mid_sum;
   logic [CW-1:0] count;

   assign pop = (state_ff == S_IDLE) && job_valid;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;
   assign mem_waddr = AW'(total_ff);
   assign count = CW'(total_ff) + CW'(1);

   assign less = (rdata_ff < pos_ff);
   assign next_lo = less ? mid_ff + TW'(1) : lo_ff;
   assign next_hi = less ? hi_ff : mid_ff;
   assign mid_sum = {1'b0, next_lo} + {1'b0, next_hi};

   always_comb begin
      state_in = state_ff;
      total_in = total_ff;
      length_in = length_ff;
      overflow_in = overflow_ff;
      lo_in = lo_ff;
      hi_in = hi_ff;
      mid_in = mid_ff;
      below_in = below_ff;
      pos_in = pos_ff;
      status_in = status_ff;
      found_in = found_ff;
      first_in = first_ff;
      start_in = start_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in = rsp_data_ff;
      mem_we = 1'b0;
      mem_raddr = AW'(mid_ff);

      unique case (state_ff)
         S_IDLE: begin
            if (job_valid) begin
               state_in = S_EMIT;
               status_in = ST_READY;
               found_in = '0;
               first_in = 1'b0;
               start_in = '0;
               if (job.op == OP_CLEAR) begin
                  total_in = '0;
                  length_in = '0;
                  overflow_in = 1'b0;
               end else if (overflow_ff) begin
                  status_in = ST_MEMORY;
               end else begin
                  unique case (job.op)
                     OP_APPEND_TEXT: begin
                        if (length_ff == POSITION_MAX) begin
                           status_in = ST_RANGE;
                        end else begin
                           length_in = length_ff + PB'(1);
                        end
                     end
                     OP_APPEND_BREAK: begin
                        if (length_ff == POSITION_MAX) begin
                           status_in = ST_RANGE;
                        end else if (total_ff == TW'(MAX_BREAKS)) begin
                           overflow_in = 1'b1;
                           status_in = ST_MEMORY;
                        end else begin
                           mem_we = 1'b1;
                           total_in = total_ff + TW'(1);
                           length_in = length_ff + PB'(1);
                        end
                     end
                     OP_LOCATE: begin
                        if (job.position > length_ff) begin
                           status_in = ST_RANGE;
                        end else begin
                           lo_in = '0;
                           hi_in = total_ff;
                           mid_in = total_ff >> 1;
                           mem_raddr = AW'(total_ff >> 1);
                           below_in = '0;
                           pos_in = job.position;
                           state_in = S_SEARCH;
                        end
                     end
                     OP_START_FIRST: begin
                        start_in = '0;
                     end
                     OP_START_TABLE: begin
                        if (32'(job.line_number) > 32'(total_ff) + 32'd1) begin
                           status_in = ST_RANGE;
                        end else begin
                           mem_raddr = AW'(job.line_number - LINE_BITS'(2));
                           state_in = S_READ;
                        end
                     end
                     OP_START_BAD: begin
                        status_in = ST_RANGE;
                     end
                     OP_CLEAR: begin
                        status_in = ST_READY;
                     end
                     default: begin
                        status_in = ST_READY;
                     end
                  endcase
               end
            end
         end
         S_SEARCH: begin
            if (lo_ff < hi_ff) begin
               lo_in = next_lo;
               hi_in = next_hi;
               mid_in = TW'(mid_sum >> 1);
               mem_raddr = AW'(mid_sum >> 1);
               if (less) begin
                  below_in = rdata_ff;
               end
            end else begin
               found_in = LINE_BITS'({1'b0, lo_ff} + (TW + 1)'(1));
               first_in = (pos_ff == '0) ||
                  ((lo_ff != '0) && (({1'b0, below_ff} + (PB + 1)'(1)) == {1'b0, pos_ff}));
               state_in = S_EMIT;
            end
         end
         S_READ: begin
            start_in = rdata_ff + PB'(1);
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.status = status_ff;
               rsp_data_in.found_line = found_ff;
               rsp_data_in.line_first = first_ff;
               rsp_data_in.start_position = start_ff;
               rsp_data_in.line_count = LINE_BITS'(count);
               rsp_data_in.digit_count = lbi_digits(32'(count));
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         total_ff <= '0;
         length_ff <= '0;
         overflow_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         total_ff <= total_in;
         length_ff <= length_in;
         overflow_ff <= overflow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      mid_ff <= mid_in;
      below_ff <= below_in;
      pos_ff <= pos_in;
      status_ff <= status_in;
      found_ff <= found_in;
      first_ff <= first_in;
      start_ff <= start_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         break_table_ff[mem_waddr] <= length_ff;
      end
      rdata_ff <= break_table_ff[mem_raddr];
   end

endmodule

`default_nettype wire

### design/line_break_index_core.sv
// An accepted request waits in a queue slot, is decoded by the back end, and its result is
// registered for output. Start of a later line adds one table read (S_READ), and locate adds
// binary-search steps (S_SEARCH), at most floor(log2(breaks)) + 1 of them (11 with 1024
// breaks, one table read each); append, clear, start of line 1 and any out-of-range query need
// neither. The back end holds one request at a time, also while its result is stalled; a
// two-entry queue takes new requests meanwhile. Reset clears the break count, text length,
// failure flag and all handshakes; table contents are left undefined and only used once written.
`default_nettype none

module line_break_index_core #(
   parameter int unsigned MAX_BREAKS = 1024
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire lbi_pkg::lbi_req_type req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output lbi_pkg::lbi_rsp_type      rsp_data
);
   import lbi_pkg::*;

   lbi_job_type push_job;
   lbi_job_type head_job;
   logic push, pop, queue_full, queue_not_empty;

   lbi_front u_front (
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .queue_full (queue_full),
      .push       (push),
      .job        (push_job)
   );

   lbi_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .pop       (pop),
      .full      (queue_full),
      .not_empty (queue_not_empty),
      .head_job  (head_job)
   );

   lbi_back #(
      .MAX_BREAKS (MAX_BREAKS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (queue_not_empty),
      .job       (head_job),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
